[design/ffha_pkg.sv]
`timescale 1ns / 1ps

package ffha_pkg;

  // Fixed widths of the item fields and the limit register.
  localparam int ADDR_W  = 12;
  localparam int REQ_W   = 15;
  localparam int LIMIT_W = 13;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

  // Header layout: size above the two flag bits.
  localparam int USED_BIT = 0;
  localparam int PF_BIT   = 1;

  // Heap start-up image: prologue at words 1 and 2, epilogue at word 3.
  localparam int PROLOGUE_WORDS = 2;
  localparam int BOOT_WORDS     = 4;

  // Request sizes are rounded up to this alignment in bytes (log2).
  localparam int ALIGN_SHIFT = 3;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [4:0] {
    ST_INIT1, ST_INIT2, ST_INIT3, ST_IDLE, ST_DISPATCH,
    ST_A_RD, ST_A_EV, ST_A_S2, ST_A_S3, ST_A_N2, ST_A_N3,
    ST_G_E1, ST_G_E2, ST_G_CK, ST_G_W2,
    ST_F_RD, ST_F_EV, ST_F_P, ST_F_NE, ST_F_W1, ST_F_W2, ST_F_W3, ST_F_W4,
    ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_INIT1, OP_INIT2, OP_INIT3, OP_LATCH, OP_RD_I, OP_ADV,
    OP_FIT_SPLIT, OP_SPLIT_REM, OP_SPLIT_FOOT, OP_FIT_WHOLE, OP_RD_NEXT_BLK,
    OP_CLR_PF, OP_RD_EPI, OP_RD_EPI_FOOT, OP_START_EPI, OP_START_FOOT,
    OP_GROW_FAIL, OP_GROW_HDR, OP_GROW_EPI, OP_FREE_HDR, OP_FREE_PREV,
    OP_FREE_NEXT, OP_FREE_HDR_W, OP_FREE_FOOT_W, OP_RD_NXT, OP_SET_PF, OP_OUT
  } op_t;

  typedef struct packed {
    logic func;
    logic p_lt2;
    logic i_lt_epi;
    logic sz_zero;
    logic fit;
    logic split;
    logic used;
    logic pf_set;
    logic i_eq_h;
    logic i_gt_h;
    logic h_lt3;
    logic grow_fail;
    logic out_free;
  } dp_status_t;

endpackage

[design/first_fit_heap_allocator.sv]
`timescale 1ns / 1ps
// An allocation walks the block headers until one fits, else it grows the heap at the epilogue;
// a free walks to its header and merges it with free neighbours, and an ignored free ends early.
// The walk reads one header at a time through the single read port of the heap memory.
// One item is in work at a time; the next can be taken in the cycle after the result is registered,
// and a stalled output register holds the sequencer until it drains.
// Reset: synchronous on rst_n low; start-up states INIT1 to INIT3 with in_stall high, limit resets to 4096.
module first_fit_heap_allocator #(
  parameter int HEAP_WORDS      = 4096,
  parameter int MIN_BLOCK_WORDS = 2,
  parameter int WORD_BYTES      = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [ffha_pkg::REQ_W-1:0]    in_request_bytes,
  input  logic [ffha_pkg::ADDR_W-1:0]   in_free_word_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ffha_pkg::ADDR_W-1:0]   out_payload_word_address,
  output logic                          out_status,
  input  logic                          cfg_wr_en,
  input  logic [ffha_pkg::LIMIT_W-1:0]  cfg_wr_data
);

  ffha_pkg::op_t        cmd;
  ffha_pkg::dp_status_t st;

  // Sequencer.
  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // Heap memory and walk registers.
  ffha_datapath #(
    .HEAP_WORDS      (HEAP_WORDS),
    .MIN_BLOCK_WORDS (MIN_BLOCK_WORDS),
    .WORD_BYTES      (WORD_BYTES)
  ) u_dp (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cmd                      (cmd),
    .st                       (st),
    .in_func                  (in_func),
    .in_request_bytes         (in_request_bytes),
    .in_free_word_address     (in_free_word_address),
    .out_valid                (out_valid),
    .out_stall                (out_stall),
    .out_payload_word_address (out_payload_word_address),
    .out_status               (out_status),
    .cfg_wr_en                (cfg_wr_en),
    .cfg_wr_data              (cfg_wr_data)
  );

endmodule

[design/ffha_ctrl.sv]
`timescale 1ns / 1ps

module ffha_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ffha_pkg::dp_status_t st,
  output ffha_pkg::op_t      cmd
);

  ffha_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffha_pkg::ST_INIT1;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath command.
  always_comb begin
    state_nxt = state_r;
    cmd       = ffha_pkg::OP_NOP;
    in_stall  = (state_r != ffha_pkg::ST_IDLE);
    case (state_r)
      ffha_pkg::ST_INIT1: begin
        cmd = ffha_pkg::OP_INIT1;
        state_nxt = ffha_pkg::ST_INIT2;
      end
      ffha_pkg::ST_INIT2: begin
        cmd = ffha_pkg::OP_INIT2;
        state_nxt = ffha_pkg::ST_INIT3;
      end
      ffha_pkg::ST_INIT3: begin
        cmd = ffha_pkg::OP_INIT3;
        state_nxt = ffha_pkg::ST_IDLE;
      end
      ffha_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd = ffha_pkg::OP_LATCH;
          state_nxt = ffha_pkg::ST_DISPATCH;
        end
      end
      ffha_pkg::ST_DISPATCH: begin
        if (st.func == ffha_pkg::FUNC_ALLOC) begin
          state_nxt = ffha_pkg::ST_A_RD;
        end else if (st.p_lt2) begin
          state_nxt = ffha_pkg::ST_DONE;
        end else begin
          state_nxt = ffha_pkg::ST_F_RD;
        end
      end
      // First-fit walk over the block list.
      ffha_pkg::ST_A_RD: begin
        if (st.i_lt_epi) begin
          cmd = ffha_pkg::OP_RD_I;
          state_nxt = ffha_pkg::ST_A_EV;
        end else begin
          cmd = ffha_pkg::OP_RD_EPI;
          state_nxt = ffha_pkg::ST_G_E1;
        end
      end
      ffha_pkg::ST_A_EV: begin
        if (st.sz_zero) begin
          cmd = ffha_pkg::OP_RD_EPI;
          state_nxt = ffha_pkg::ST_G_E1;
        end else if (st.fit && st.split) begin
          cmd = ffha_pkg::OP_FIT_SPLIT;
          state_nxt = ffha_pkg::ST_A_S2;
        end else if (st.fit) begin
          cmd = ffha_pkg::OP_FIT_WHOLE;
          state_nxt = ffha_pkg::ST_A_N2;
        end else begin
          cmd = ffha_pkg::OP_ADV;
          state_nxt = ffha_pkg::ST_A_RD;
        end
      end
      ffha_pkg::ST_A_S2: begin
        cmd = ffha_pkg::OP_SPLIT_REM;
        state_nxt = ffha_pkg::ST_A_S3;
      end
      ffha_pkg::ST_A_S3: begin
        cmd = ffha_pkg::OP_SPLIT_FOOT;
        state_nxt = ffha_pkg::ST_DONE;
      end
      ffha_pkg::ST_A_N2: begin
        cmd = ffha_pkg::OP_RD_NEXT_BLK;
        state_nxt = ffha_pkg::ST_A_N3;
      end
      ffha_pkg::ST_A_N3: begin
        cmd = ffha_pkg::OP_CLR_PF;
        state_nxt = ffha_pkg::ST_DONE;
      end
      // Growth at the epilogue, absorbing a trailing free block.
      ffha_pkg::ST_G_E1: begin
        if (st.pf_set) begin
          cmd = ffha_pkg::OP_RD_EPI_FOOT;
          state_nxt = ffha_pkg::ST_G_E2;
        end else begin
          cmd = ffha_pkg::OP_START_EPI;
          state_nxt = ffha_pkg::ST_G_CK;
        end
      end
      ffha_pkg::ST_G_E2: begin
        cmd = ffha_pkg::OP_START_FOOT;
        state_nxt = ffha_pkg::ST_G_CK;
      end
      ffha_pkg::ST_G_CK: begin
        if (st.grow_fail) begin
          cmd = ffha_pkg::OP_GROW_FAIL;
          state_nxt = ffha_pkg::ST_DONE;
        end else begin
          cmd = ffha_pkg::OP_GROW_HDR;
          state_nxt = ffha_pkg::ST_G_W2;
        end
      end
      ffha_pkg::ST_G_W2: begin
        cmd = ffha_pkg::OP_GROW_EPI;
        state_nxt = ffha_pkg::ST_DONE;
      end
      // Free: find the header by walking, then coalesce.
      ffha_pkg::ST_F_RD: begin
        if (st.i_lt_epi) begin
          cmd = ffha_pkg::OP_RD_I;
          state_nxt = ffha_pkg::ST_F_EV;
        end else begin
          state_nxt = ffha_pkg::ST_DONE;
        end
      end
      ffha_pkg::ST_F_EV: begin
        if (st.i_eq_h) begin
          if (st.h_lt3 || !st.used || st.sz_zero) begin
            state_nxt = ffha_pkg::ST_DONE;
          end else begin
            cmd = ffha_pkg::OP_FREE_HDR;
            state_nxt = st.pf_set ? ffha_pkg::ST_F_P : ffha_pkg::ST_F_NE;
          end
        end else if (st.sz_zero || st.i_gt_h) begin
          state_nxt = ffha_pkg::ST_DONE;
        end else begin
          cmd = ffha_pkg::OP_ADV;
          state_nxt = ffha_pkg::ST_F_RD;
        end
      end
      ffha_pkg::ST_F_P: begin
        cmd = ffha_pkg::OP_FREE_PREV;
        state_nxt = ffha_pkg::ST_F_NE;
      end
      ffha_pkg::ST_F_NE: begin
        cmd = ffha_pkg::OP_FREE_NEXT;
        state_nxt = ffha_pkg::ST_F_W1;
      end
      ffha_pkg::ST_F_W1: begin
        cmd = ffha_pkg::OP_FREE_HDR_W;
        state_nxt = ffha_pkg::ST_F_W2;
      end
      ffha_pkg::ST_F_W2: begin
        cmd = ffha_pkg::OP_FREE_FOOT_W;
        state_nxt = ffha_pkg::ST_F_W3;
      end
      ffha_pkg::ST_F_W3: begin
        cmd = ffha_pkg::OP_RD_NXT;
        state_nxt = ffha_pkg::ST_F_W4;
      end
      ffha_pkg::ST_F_W4: begin
        cmd = ffha_pkg::OP_SET_PF;
        state_nxt = ffha_pkg::ST_DONE;
      end
      // Hand the result to the output register once it has room.
      ffha_pkg::ST_DONE: begin
        if (st.out_free) begin
          cmd = ffha_pkg::OP_OUT;
          state_nxt = ffha_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ffha_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[design/ffha_datapath.sv]
`timescale 1ns / 1ps

module ffha_datapath #(
  parameter int HEAP_WORDS      = 4096,
  parameter int MIN_BLOCK_WORDS = 2,
  parameter int WORD_BYTES      = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ffha_pkg::op_t                      cmd,
  output ffha_pkg::dp_status_t               st,
  input  logic                               in_func,
  input  logic [ffha_pkg::REQ_W-1:0]         in_request_bytes,
  input  logic [ffha_pkg::ADDR_W-1:0]        in_free_word_address,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ffha_pkg::ADDR_W-1:0]        out_payload_word_address,
  output logic                               out_status,
  input  logic                               cfg_wr_en,
  input  logic [ffha_pkg::LIMIT_W-1:0]       cfg_wr_data
);

  localparam int AW  = $clog2(HEAP_WORDS);
  localparam int MW  = AW + 2;
  localparam int CW  = (AW + 2 > 17) ? AW + 2 : 17;
  localparam int WBS = $clog2(WORD_BYTES);

  // Heap memory: one read port with registered data, one write port.
  logic [MW-1:0] heap_mem [HEAP_WORDS];
  logic [MW-1:0] rdata_r;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [MW-1:0] wr_data;

  // Walk and merge registers.
  logic [AW-1:0] i_r, i_nxt;
  logic [CW-1:0] need_r, need_nxt;
  logic [CW-1:0] h_r, h_nxt;
  logic [AW-1:0] sz_r, sz_nxt;
  logic [AW-1:0] start_r, start_nxt;
  logic [AW-1:0] nxt_r, nxt_nxt;
  logic [AW-1:0] s_r, s_nxt;
  logic [AW-1:0] epi_r, epi_nxt;
  logic [AW-1:0] res_addr_r, res_addr_nxt;
  logic          res_st_r, res_st_nxt;
  logic          func_r, func_nxt;
  logic          p_lt2_r, p_lt2_nxt;
  logic [ffha_pkg::LIMIT_W-1:0] limit_r;
  logic          out_valid_r;
  logic [AW-1:0] out_addr_r;
  logic          out_status_r;

  logic [AW-1:0] rd_sz;
  logic [CW-1:0] bytes_c, need_c, limit_c, rem_c;

  assign rd_sz = rdata_r[MW-1:2];

  // Request size in words, and the limit in effect.
  always_comb begin
    bytes_c = ((CW'(in_request_bytes) + CW'(WORD_BYTES) + CW'(7)) >> ffha_pkg::ALIGN_SHIFT)
              << ffha_pkg::ALIGN_SHIFT;
    need_c  = (bytes_c + CW'(WORD_BYTES - 1)) >> WBS;
    limit_c = (CW'(limit_r) < CW'(HEAP_WORDS)) ? CW'(limit_r) : CW'(HEAP_WORDS);
    rem_c   = CW'(rd_sz) - need_r;
  end

  // Status toward the controller.
  always_comb begin
    st.func      = func_r;
    st.p_lt2     = p_lt2_r;
    st.i_lt_epi  = (i_r < epi_r);
    st.sz_zero   = (rd_sz == '0);
    st.fit       = !rdata_r[ffha_pkg::USED_BIT] && (CW'(rd_sz) >= need_r);
    st.split     = (rem_c >= CW'(MIN_BLOCK_WORDS));
    st.used      = rdata_r[ffha_pkg::USED_BIT];
    st.pf_set    = rdata_r[ffha_pkg::PF_BIT];
    st.i_eq_h    = (CW'(i_r) == h_r);
    st.i_gt_h    = (CW'(i_r) > h_r);
    st.h_lt3     = (h_r < CW'(ffha_pkg::BOOT_WORDS - 1));
    st.grow_fail = (CW'(start_r) + need_r + CW'(1) > limit_c);
    st.out_free  = !out_valid_r || !out_stall;
  end

  // Command decode: memory accesses and register updates.
  always_comb begin
    rd_en        = 1'b0;
    rd_addr      = i_r;
    wr_en        = 1'b0;
    wr_addr      = i_r;
    wr_data      = '0;
    i_nxt        = i_r;
    need_nxt     = need_r;
    h_nxt        = h_r;
    sz_nxt       = sz_r;
    start_nxt    = start_r;
    nxt_nxt      = nxt_r;
    s_nxt        = s_r;
    epi_nxt      = epi_r;
    res_addr_nxt = res_addr_r;
    res_st_nxt   = res_st_r;
    func_nxt     = func_r;
    p_lt2_nxt    = p_lt2_r;
    case (cmd)
      ffha_pkg::OP_INIT1: begin
        wr_en   = 1'b1;
        wr_addr = AW'(1);
        wr_data = {AW'(ffha_pkg::PROLOGUE_WORDS), 1'b0, 1'b1};
      end
      ffha_pkg::OP_INIT2: begin
        wr_en   = 1'b1;
        wr_addr = AW'(2);
        wr_data = {AW'(ffha_pkg::PROLOGUE_WORDS), 1'b0, 1'b1};
      end
      ffha_pkg::OP_INIT3: begin
        wr_en   = 1'b1;
        wr_addr = AW'(ffha_pkg::BOOT_WORDS - 1);
        wr_data = {AW'(0), 1'b0, 1'b1};
      end
      ffha_pkg::OP_LATCH: begin
        func_nxt     = in_func;
        need_nxt     = need_c;
        h_nxt        = CW'(in_free_word_address) - CW'(1);
        p_lt2_nxt    = (in_free_word_address < ffha_pkg::ADDR_W'(2));
        i_nxt        = AW'(1);
        res_addr_nxt = '0;
        res_st_nxt   = 1'b0;
      end
      ffha_pkg::OP_RD_I: begin
        rd_en   = 1'b1;
        rd_addr = i_r;
      end
      ffha_pkg::OP_ADV: begin
        i_nxt = i_r + rd_sz;
      end
      ffha_pkg::OP_FIT_SPLIT: begin
        wr_en        = 1'b1;
        wr_addr      = i_r;
        wr_data      = {need_r[AW-1:0], 1'b0, 1'b1};
        sz_nxt       = rd_sz;
        res_addr_nxt = i_r + AW'(1);
      end
      ffha_pkg::OP_SPLIT_REM: begin
        wr_en   = 1'b1;
        wr_addr = i_r + need_r[AW-1:0];
        wr_data = {sz_r - need_r[AW-1:0], 1'b0, 1'b0};
      end
      ffha_pkg::OP_SPLIT_FOOT: begin
        wr_en   = 1'b1;
        wr_addr = i_r + sz_r - AW'(1);
        wr_data = {sz_r - need_r[AW-1:0], 1'b0, 1'b0};
      end
      ffha_pkg::OP_FIT_WHOLE: begin
        wr_en        = 1'b1;
        wr_addr      = i_r;
        wr_data      = {rd_sz, 1'b0, 1'b1};
        sz_nxt       = rd_sz;
        res_addr_nxt = i_r + AW'(1);
      end
      ffha_pkg::OP_RD_NEXT_BLK: begin
        rd_en   = 1'b1;
        rd_addr = i_r + sz_r;
      end
      ffha_pkg::OP_CLR_PF: begin
        wr_en   = 1'b1;
        wr_addr = i_r + sz_r;
        wr_data = rdata_r & ~(MW'(1) << ffha_pkg::PF_BIT);
      end
      ffha_pkg::OP_RD_EPI: begin
        rd_en   = 1'b1;
        rd_addr = epi_r;
      end
      ffha_pkg::OP_RD_EPI_FOOT: begin
        rd_en   = 1'b1;
        rd_addr = epi_r - AW'(1);
      end
      ffha_pkg::OP_START_EPI: begin
        start_nxt = epi_r;
      end
      ffha_pkg::OP_START_FOOT: begin
        start_nxt = (rd_sz <= epi_r) ? epi_r - rd_sz : epi_r;
      end
      ffha_pkg::OP_GROW_FAIL: begin
        res_st_nxt   = 1'b1;
        res_addr_nxt = '0;
      end
      ffha_pkg::OP_GROW_HDR: begin
        wr_en        = 1'b1;
        wr_addr      = start_r;
        wr_data      = {need_r[AW-1:0], 1'b0, 1'b1};
        epi_nxt      = start_r + need_r[AW-1:0];
        res_addr_nxt = start_r + AW'(1);
      end
      ffha_pkg::OP_GROW_EPI: begin
        wr_en   = 1'b1;
        wr_addr = epi_r;
        wr_data = {AW'(0), 1'b0, 1'b1};
      end
      ffha_pkg::OP_FREE_HDR: begin
        s_nxt     = rd_sz;
        start_nxt = h_r[AW-1:0];
        nxt_nxt   = h_r[AW-1:0] + rd_sz;
        rd_en     = 1'b1;
        rd_addr   = rdata_r[ffha_pkg::PF_BIT] ? h_r[AW-1:0] - AW'(1)
                                              : h_r[AW-1:0] + rd_sz;
      end
      ffha_pkg::OP_FREE_PREV: begin
        if (CW'(rd_sz) <= h_r) begin
          start_nxt = h_r[AW-1:0] - rd_sz;
          s_nxt     = s_r + rd_sz;
        end
        rd_en   = 1'b1;
        rd_addr = nxt_r;
      end
      ffha_pkg::OP_FREE_NEXT: begin
        if (!rdata_r[ffha_pkg::USED_BIT]) begin
          s_nxt   = s_r + rd_sz;
          nxt_nxt = nxt_r + rd_sz;
        end
      end
      ffha_pkg::OP_FREE_HDR_W: begin
        wr_en   = 1'b1;
        wr_addr = start_r;
        wr_data = {s_r, 1'b0, 1'b0};
      end
      ffha_pkg::OP_FREE_FOOT_W: begin
        wr_en   = 1'b1;
        wr_addr = start_r + s_r - AW'(1);
        wr_data = {s_r, 1'b0, 1'b0};
      end
      ffha_pkg::OP_RD_NXT: begin
        rd_en   = 1'b1;
        rd_addr = nxt_r;
      end
      ffha_pkg::OP_SET_PF: begin
        wr_en   = 1'b1;
        wr_addr = nxt_r;
        wr_data = rdata_r | (MW'(1) << ffha_pkg::PF_BIT);
      end
      default: begin
      end
    endcase
  end

  // Heap memory ports.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= heap_mem[rd_addr];
    end
  end

  // Payload registers of the walk.
  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    need_r     <= need_nxt;
    h_r        <= h_nxt;
    sz_r       <= sz_nxt;
    start_r    <= start_nxt;
    nxt_r      <= nxt_nxt;
    s_r        <= s_nxt;
    res_addr_r <= res_addr_nxt;
    res_st_r   <= res_st_nxt;
    func_r     <= func_nxt;
    p_lt2_r    <= p_lt2_nxt;
  end

  // Heap extent and limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epi_r   <= AW'(ffha_pkg::BOOT_WORDS - 1);
      limit_r <= ffha_pkg::LIMIT_RESET;
    end else begin
      epi_r <= epi_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd == ffha_pkg::OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == ffha_pkg::OP_OUT) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= res_st_r;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_payload_word_address = ffha_pkg::ADDR_W'(out_addr_r);
  assign out_status               = out_status_r;

endmodule
